### rtl/core/scap_pkg.sv
`timescale 1ns / 1ps

package scap_pkg;

  // Initial character values for the two coding conventions.
  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  // Low nibble of T0 carries K, the number of historical bytes.
  localparam logic [3:0] K_MASK = 4'hF;

  localparam logic [3:0] GROUP_MAX = 4'd15;
  localparam logic [3:0] HIST_MAX  = 4'd15;

  typedef enum logic [2:0] {
    PH_TS    = 3'd0,
    PH_T0    = 3'd1,
    PH_IFACE = 3'd2,
    PH_HIST  = 3'd3,
    PH_TCK   = 3'd4,
    PH_SKIP  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_TS   = 2'd1,
    ERR_LEN  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ROLE_TS   = 4'd0,
    ROLE_T0   = 4'd1,
    ROLE_TA   = 4'd2,
    ROLE_TB   = 4'd3,
    ROLE_TC   = 4'd4,
    ROLE_TD   = 4'd5,
    ROLE_HIST = 4'd6,
    ROLE_TCK  = 4'd7,
    ROLE_IGN  = 4'd8
  } role_t;

  typedef enum logic [1:0] {
    CONV_DIRECT  = 2'd0,
    CONV_INVERSE = 2'd1,
    CONV_INVALID = 2'd2
  } conv_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_BAD_TS   = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] pending;
    logic [3:0] group_count;
    logic [3:0] hist_remaining;
    logic [3:0] hist_count;
    logic [7:0] check;
    err_t       err;
    conv_t      conv;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_TS,
    pending:        4'd0,
    group_count:    4'd0,
    hist_remaining: 4'd0,
    hist_count:     4'd0,
    check:          8'd0,
    err:            ERR_NONE,
    conv:           CONV_DIRECT
  };

  typedef struct packed {
    logic [7:0] expected_check;
    status_t    final_status;
    conv_t      convention;
    logic [3:0] hist_index;
    logic [3:0] group_index;
    role_t      byte_role;
  } result_t;

  localparam int unsigned OUT_TDATA_W = 32;

endpackage

### rtl/core/scap_classify.sv
`timescale 1ns / 1ps

module scap_classify (
  input  scap_pkg::parse_state_t state,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output scap_pkg::parse_state_t state_next,
  output scap_pkg::result_t      result
);
  import scap_pkg::*;

  parse_state_t nxt;
  role_t        role;
  logic [3:0]   grp;
  logic [3:0]   hidx;
  status_t      status;

  // Where parsing goes once an interface byte or T0 has been consumed.
  function automatic phase_t after_iface(input logic [3:0] pend, input logic [3:0] hrem);
    phase_t ph;
    if (pend != 4'd0) begin
      ph = PH_IFACE;
    end else if (hrem != 4'd0) begin
      ph = PH_HIST;
    end else begin
      ph = PH_TCK;
    end
    return ph;
  endfunction

  always_comb begin
    nxt    = state;
    role   = ROLE_IGN;
    grp    = 4'd0;
    hidx   = 4'd0;
    status = ST_BUSY;

    case (state.phase)
      PH_TS: begin
        role = ROLE_TS;
        if (data_byte == TS_DIRECT) begin
          nxt.conv  = CONV_DIRECT;
          nxt.phase = PH_T0;
          status    = ST_LENGTH;
        end else if (data_byte == TS_INVERSE) begin
          nxt.conv  = CONV_INVERSE;
          nxt.phase = PH_T0;
          status    = ST_LENGTH;
        end else begin
          nxt.conv  = CONV_INVALID;
          nxt.err   = ERR_TS;
          nxt.phase = PH_SKIP;
          status    = ST_BAD_TS;
        end
      end
      PH_T0: begin
        role               = ROLE_T0;
        nxt.pending        = data_byte[7:4];
        nxt.hist_remaining = data_byte[3:0] & K_MASK;
        nxt.hist_count     = 4'd0;
        nxt.group_count    = 4'd1;
        nxt.check          = data_byte;
        nxt.phase          = after_iface(data_byte[7:4], data_byte[3:0] & K_MASK);
        status             = ST_LENGTH;
      end
      PH_IFACE: begin
        grp       = state.group_count;
        nxt.check = state.check ^ data_byte;
        // Lowest pending presence bit picks TA, TB, TC; otherwise TD.
        if (state.pending[0]) begin
          role           = ROLE_TA;
          nxt.pending[0] = 1'b0;
        end else if (state.pending[1]) begin
          role           = ROLE_TB;
          nxt.pending[1] = 1'b0;
        end else if (state.pending[2]) begin
          role           = ROLE_TC;
          nxt.pending[2] = 1'b0;
        end else begin
          role        = ROLE_TD;
          nxt.pending = data_byte[7:4];
          if (state.group_count < GROUP_MAX) begin
            nxt.group_count = state.group_count + 4'd1;
          end
        end
        nxt.phase = after_iface(nxt.pending, state.hist_remaining);
        status    = ST_LENGTH;
      end
      PH_HIST: begin
        status = ST_LENGTH;
        if (last_byte) begin
          role = ROLE_TCK;
        end else begin
          role = ROLE_HIST;
          if (state.hist_count < HIST_MAX) begin
            nxt.hist_count = state.hist_count + 4'd1;
          end
          hidx      = nxt.hist_count;
          nxt.check = state.check ^ data_byte;
          if (state.hist_remaining > 4'd0) begin
            nxt.hist_remaining = state.hist_remaining - 4'd1;
          end
          if (nxt.hist_remaining == 4'd0) begin
            nxt.phase = PH_TCK;
          end
        end
      end
      PH_TCK: begin
        if (last_byte) begin
          role   = ROLE_TCK;
          status = (data_byte == state.check) ? ST_OK : ST_CHECKSUM;
        end else begin
          role      = ROLE_IGN;
          nxt.err   = ERR_LEN;
          nxt.phase = PH_SKIP;
        end
      end
      default: begin
        if (state.err == ERR_TS) begin
          role   = ROLE_IGN;
          status = ST_BAD_TS;
        end else begin
          role   = last_byte ? ROLE_TCK : ROLE_IGN;
          status = ST_LENGTH;
        end
      end
    endcase

    result.byte_role      = role;
    result.group_index    = grp;
    result.hist_index     = hidx;
    result.convention     = nxt.conv;
    result.final_status   = last_byte ? status : ST_BUSY;
    result.expected_check = last_byte ? state.check : 8'd0;

    // The final byte closes the ATR; the next byte is a fresh TS.
    state_next = last_byte ? STATE_RESET : nxt;
  end

endmodule

### rtl/core/smart_card_atr_parser.sv
`timescale 1ns / 1ps

// Answer-To-Reset parser for smart cards. ATR bytes enter on the s_axis
// channel, one byte per word, with s_tlast set on the final byte of the ATR.
// Every accepted word yields exactly one result word on the m_axis channel:
// the role of the byte (TS, T0, TA..TD, historical, TCK or ignored), its
// interface group or historical index, and the convention seen in TS. On the
// word that carries m_tlast the final status and the expected check value
// (XOR of T0 up to the byte before the last) are valid; elsewhere they are 0.
// Results are registered. Throughput is one word per cycle while the receiver
// keeps up, set by the combinational classifier between the parse state
// register and the result register. A two-entry output stage (result
// register plus skid register) lets the block keep taking words while a
// result waits. When the receiver stalls, at most two results are held and
// s_tready drops until the skid entry drains. Synchronous reset clears the
// parse state to "expect TS" and empties the output stage; the first word
// after reset or after any final byte is read as TS.
module smart_card_atr_parser (
  input  logic        clk,
  input  logic        rst,
  // s_tdata fields from bit 0: data_byte[7:0]
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,   // last_byte
  input  logic        s_tvalid,
  output logic        s_tready,
  // m_tdata fields from bit 0: byte_role[3:0], group_index[7:4],
  // hist_index[11:8], convention[13:12], final_status[16:14],
  // expected_check[24:17], zero fill[31:25]
  output logic [scap_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic        m_tlast,   // end_of_atr
  output logic        m_tvalid,
  input  logic        m_tready
);
  import scap_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  result_t      new_res;

  result_t out_res;
  logic    out_last;
  logic    out_valid;
  result_t skid_res;
  logic    skid_last;
  logic    skid_valid;

  logic    in_accept;

  scap_classify u_classify (
    .state      (state),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .state_next (state_next),
    .result     (new_res)
  );

  // Input is taken whenever the skid register is free.
  assign s_tready  = ~skid_valid;
  assign in_accept = s_tvalid & s_tready;

  // Parse state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output stage: the result register feeds the port; the skid register
  // catches a word accepted while the result register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        out_last <= skid_last;
      end else if (in_accept) begin
        out_res  <= new_res;
        out_last <= s_tlast;
      end
    end else if (in_accept) begin
      skid_res  <= new_res;
      skid_last <= s_tlast;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res};

  // The skid entry is only ever filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while result register empty");

  // A final byte always returns the parser to expecting TS.
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tlast) |=> (state.phase == PH_TS))
    else $error("parse state not reset after final byte");

  // Status and check value appear only on the closing word.
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_res.final_status == ST_BUSY &&
                                  out_res.expected_check == 8'd0))
    else $error("final status reported before end of ATR");

  // A group number is given only for interface bytes.
  a_group_only_iface: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.group_index != 4'd0) |->
      (out_res.byte_role == ROLE_TA || out_res.byte_role == ROLE_TB ||
       out_res.byte_role == ROLE_TC || out_res.byte_role == ROLE_TD))
    else $error("group index on a non-interface byte");

endmodule
